[hdl/quoted_argument_tokenizer_unit_defines.svh]
// Assertion macros used by the checker file of the tokenizer unit.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define QATU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define QATU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/qat_pkg.sv]
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quoted argument tokenizer modules.
// ----------------------------------------------------------------------------
package qat_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int OUT_BYTE_MSB  = 7;
   localparam int STORE_BIT     = 8;
   localparam int NEW_ARG_BIT   = 9;
   localparam int ARG_END_BIT   = 10;
   localparam int QUOTE_ERR_BIT = 16;
   localparam int ARG_CNT_LSB   = 17;
   localparam int ARG_CNT_MSB   = 20;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_SEEK   = 3'd0,
      MODE_QUOTED = 3'd1,
      MODE_QESC   = 3'd2,
      MODE_PLAIN  = 3'd3,
      MODE_PESC   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       store;
      logic       new_arg;
      logic       arg_end;
      logic [3:0] arg_index;
      logic       recorded;
      logic       line_end;
      logic       quote_error;
      logic [3:0] arg_count;
   } rsp_type;

endpackage

[hdl/qat_step.sv]
// ----------------------------------------------------------------------------
// qat_step
// Per-byte tokenizer decision: result fields and next scan state.
// ----------------------------------------------------------------------------
module qat_step #(
   parameter int MAX_ARGS = 16
) (
   input  logic [7:0]                    ch,
   input  qat_pkg::mode_type             mode_ff,
   input  logic [$clog2(MAX_ARGS)-1:0]   args_ff,
   input  logic                          rec_ff,
   output qat_pkg::mode_type             mode_in,
   output logic [$clog2(MAX_ARGS)-1:0]   args_in,
   output logic                          rec_in,
   output qat_pkg::rsp_type              res
);

   localparam int AW = $clog2(MAX_ARGS);
   localparam logic [AW-1:0] LIMIT = AW'(MAX_ARGS - 1);
   localparam logic [AW-1:0] ONE   = AW'(1);

   logic          blank;
   logic          in_arg;
   logic [AW+3:0] idx_w;
   logic [AW+3:0] cnt_w;

   assign blank = (ch inside {[qat_pkg::CH_TAB:qat_pkg::CH_CR], qat_pkg::CH_SPACE});

   always_comb begin
      res     = '0;
      mode_in = mode_ff;
      args_in = args_ff;
      rec_in  = rec_ff;
      in_arg  = 1'b0;
      idx_w   = '0;
      cnt_w   = '0;

      case (mode_ff)
         qat_pkg::MODE_QUOTED, qat_pkg::MODE_QESC: begin
            in_arg = 1'b1;
            if (ch == qat_pkg::CH_NUL) begin
               res.line_end    = 1'b1;
               res.quote_error = 1'b1;
            end else if (mode_ff == qat_pkg::MODE_QESC) begin
               res.out_byte = ch;
               res.store    = 1'b1;
               mode_in      = qat_pkg::MODE_QUOTED;
            end else if (ch == qat_pkg::CH_BSLASH) begin
               mode_in = qat_pkg::MODE_QESC;
            end else if (ch == qat_pkg::CH_QUOTE) begin
               res.store   = 1'b1;
               res.arg_end = 1'b1;
               mode_in     = qat_pkg::MODE_SEEK;
            end else begin
               res.out_byte = ch;
               res.store    = 1'b1;
            end
         end
         qat_pkg::MODE_PLAIN, qat_pkg::MODE_PESC: begin
            in_arg = 1'b1;
            if (ch == qat_pkg::CH_NUL) begin
               res.line_end = 1'b1;
               res.store    = 1'b1;
               res.arg_end  = 1'b1;
            end else if (mode_ff == qat_pkg::MODE_PESC) begin
               res.out_byte = ch;
               res.store    = 1'b1;
               mode_in      = qat_pkg::MODE_PLAIN;
            end else if (ch == qat_pkg::CH_BSLASH) begin
               mode_in = qat_pkg::MODE_PESC;
            end else if (blank) begin
               res.store   = 1'b1;
               res.arg_end = 1'b1;
               mode_in     = qat_pkg::MODE_SEEK;
            end else begin
               res.out_byte = ch;
               res.store    = 1'b1;
            end
         end
         default: begin
            if (ch == qat_pkg::CH_NUL) begin
               res.line_end = 1'b1;
            end else if (!blank) begin
               // First byte of a new argument; it is counted while below the limit.
               res.new_arg = 1'b1;
               idx_w       = (AW+4)'(args_ff);
               if (args_ff < LIMIT) begin
                  rec_in  = 1'b1;
                  args_in = args_ff + ONE;
               end else begin
                  rec_in = 1'b0;
               end
               res.recorded = rec_in;
               if (ch == qat_pkg::CH_QUOTE) begin
                  mode_in = qat_pkg::MODE_QUOTED;
               end else if (ch == qat_pkg::CH_BSLASH) begin
                  mode_in = qat_pkg::MODE_PESC;
               end else begin
                  res.out_byte = ch;
                  res.store    = 1'b1;
                  mode_in      = qat_pkg::MODE_PLAIN;
               end
            end
         end
      endcase

      if (in_arg) begin
         idx_w        = rec_ff ? (AW+4)'(args_ff - ONE) : (AW+4)'(args_ff);
         res.recorded = rec_ff;
      end

      if (res.line_end) begin
         cnt_w   = (AW+4)'(args_ff);
         mode_in = qat_pkg::MODE_SEEK;
         args_in = '0;
         rec_in  = 1'b0;
      end

      res.arg_index = idx_w[3:0];
      res.arg_count = cnt_w[3:0];
   end

endmodule

[hdl/quoted_argument_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_unit
// Splits a command line, one byte per beat, into whitespace separated
// arguments with double quotes and backslash escapes.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Ports                         Beat contents
//   request   in    req_tvalid/tready/tdata       one line byte, 0 ends the line
//   response  out   rsp_tvalid/tready/tdata/tlast one result per byte
//
// One byte is accepted every clock cycle when the response side keeps up.
// An accepted byte waits in the input register until the result register can
// take it; its result beat is then offered on the response channel.
// The scan state (mode, argument count, recorded flag) updates in the cycle
// a byte moves from the input register into the result register.
// Reset empties both registers and returns the scanner to seeking the head
// of an argument. A stalled response holds its beat and backs up the input.
module quoted_argument_tokenizer_unit #(
   parameter int MAX_ARGS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] ch
   input  logic [qat_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte, [8] store, [9] new_arg, [10] arg_end, [14:11] arg_index,
   // [15] recorded, [16] quote_error, [20:17] arg_count, [23:21] zero
   output logic [qat_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // line_end: the line ends with this byte
   output logic                              rsp_tlast
);

   localparam int AW = $clog2(MAX_ARGS);

   // Input register.
   logic                 in_valid_ff;
   logic [7:0]           ch_ff;

   // Result register.
   logic                 rsp_valid_ff;
   qat_pkg::rsp_type     rsp_ff;

   // Scan state and its next values.
   qat_pkg::mode_type    mode_ff;
   qat_pkg::mode_type    mode_in;
   logic [AW-1:0]        args_ff;
   logic [AW-1:0]        args_in;
   logic                 rec_ff;
   logic                 rec_in;

   qat_pkg::rsp_type     res;
   logic                 advance;
   logic                 fire;

   // The result register can take a new beat when it is empty or draining.
   assign advance    = !rsp_valid_ff || rsp_tready;
   // A byte is processed when it sits in the input register and can move on.
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   qat_step #(
      .MAX_ARGS (MAX_ARGS)
   ) u_step (
      .ch      (ch_ff),
      .mode_ff (mode_ff),
      .args_ff (args_ff),
      .rec_ff  (rec_ff),
      .mode_in (mode_in),
      .args_in (args_in),
      .rec_in  (rec_in),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= qat_pkg::MODE_SEEK;
         args_ff      <= '0;
         rec_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            mode_ff <= mode_in;
            args_ff <= args_in;
            rec_ff  <= rec_in;
         end
      end
   end

   // Payload registers carry no reset; the valid flags above guard them.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff <= req_tdata[7:0];
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.line_end;
   assign rsp_tdata  = {3'b000, rsp_ff.arg_count, rsp_ff.quote_error, rsp_ff.recorded,
                        rsp_ff.arg_index, rsp_ff.arg_end, rsp_ff.new_arg, rsp_ff.store,
                        rsp_ff.out_byte};

endmodule

[hdl/qat_checker.sv]
// ----------------------------------------------------------------------------
// qat_checker
// Port-level checks of the tokenizer unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "quoted_argument_tokenizer_unit_defines.svh"

module qat_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [qat_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [qat_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);

   logic req_beat;
   logic stalled;

   assign req_beat = req_tvalid && req_tready && (req_tdata == req_tdata);
   assign stalled  = rsp_tvalid && !rsp_tready;

   // A stalled response beat keeps its contents.
   `QATU_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response beat changed while stalled")

   // A nonzero byte on the response is always one that is stored.
   `QATU_ASSERT_NOW(a_byte_store, clock, reset, rsp_tvalid && (rsp_tdata[qat_pkg::OUT_BYTE_MSB:0] != 8'h00), rsp_tdata[qat_pkg::STORE_BIT], "nonzero out_byte without store")

   // An unmatched quote only shows at line end and neither stores nor ends an argument.
   `QATU_ASSERT_NOW(a_quote_err, clock, reset, rsp_tvalid && rsp_tdata[qat_pkg::QUOTE_ERR_BIT], rsp_tlast && !rsp_tdata[qat_pkg::STORE_BIT] && !rsp_tdata[qat_pkg::ARG_END_BIT], "quote error outside line end")

   // The argument count is zero on every beat but the last of a line.
   `QATU_ASSERT_NOW(a_count_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[qat_pkg::ARG_CNT_MSB:qat_pkg::ARG_CNT_LSB] == 4'd0, "arg_count set before line end")

   // A byte never both opens and terminates an argument; an input beat alone makes the check pass trivially.
   `QATU_ASSERT_NOW(a_open_close, clock, reset, rsp_tvalid || req_beat, !(rsp_tvalid && rsp_tdata[qat_pkg::NEW_ARG_BIT] && rsp_tdata[qat_pkg::ARG_END_BIT]), "byte both opens and ends an argument")

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (.*);

[dv/tb_quoted_argument_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_argument_tokenizer_unit
// Streams command lines through the tokenizer one byte per beat and checks
// every result beat against a cycle-free predictor of the argument scanner.
// ----------------------------------------------------------------------------
module tb_quoted_argument_tokenizer_unit;

   localparam int MAX_ARGS    = 16;
   localparam int ITEM_TARGET = 1950;
   localparam int CYCLE_LIMIT = 100000;
   localparam int IDLE_PCT    = 24;
   // Within this window of cycles neither side idles.
   localparam int CALM_FIRST  = 1000;
   localparam int CALM_LAST   = 1800;

   typedef struct {
      logic [7:0] ch;
      bit         drain;   // hold this byte back until every result has come
   } line_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [qat_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [qat_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   // Bytes still to be sent and the results predicted for bytes already taken.
   line_byte_type      line_bytes_q[$];
   qat_pkg::rsp_type   token_results_q[$];
   line_byte_type      next_byte;
   bit                 drain_next = 1'b0;
   bit                 byte_taken = 1'b0;
   int                 cycle_count = 0;
   int                 mismatch_count = 0;

   // Scanner state of the predictor.
   qat_pkg::mode_type  scan_state = qat_pkg::MODE_SEEK;
   int                 arg_total = 0;
   logic               arg_is_recorded = 1'b0;

   always #4 clock = ~clock;

   quoted_argument_tokenizer_unit #(
      .MAX_ARGS(MAX_ARGS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // Whitespace is tab through carriage return, plus the space itself.
   function automatic bit is_separator(input logic [7:0] ch);
      return (ch >= qat_pkg::CH_TAB && ch <= qat_pkg::CH_CR) || ch == qat_pkg::CH_SPACE;
   endfunction

   // Works out the result beat for one line byte and advances the scanner.
   function automatic qat_pkg::rsp_type tokenize_byte(input logic [7:0] ch);
      qat_pkg::rsp_type r;
      bit               in_arg;
      r = '0;
      in_arg = 1'b0;
      case (scan_state)
         qat_pkg::MODE_QUOTED, qat_pkg::MODE_QESC: begin
            in_arg = 1'b1;
            if (ch == qat_pkg::CH_NUL) begin
               // The line ends with the quote still open.
               r.line_end = 1'b1;
               r.quote_error = 1'b1;
            end else if (scan_state == qat_pkg::MODE_QESC) begin
               r.out_byte = ch;
               r.store = 1'b1;
               scan_state = qat_pkg::MODE_QUOTED;
            end else if (ch == qat_pkg::CH_BSLASH) begin
               scan_state = qat_pkg::MODE_QESC;
            end else if (ch == qat_pkg::CH_QUOTE) begin
               r.store = 1'b1;
               r.arg_end = 1'b1;
               scan_state = qat_pkg::MODE_SEEK;
            end else begin
               r.out_byte = ch;
               r.store = 1'b1;
            end
         end
         qat_pkg::MODE_PLAIN, qat_pkg::MODE_PESC: begin
            in_arg = 1'b1;
            if (ch == qat_pkg::CH_NUL) begin
               // Line end terminates a plain argument, even after a backslash.
               r.line_end = 1'b1;
               r.store = 1'b1;
               r.arg_end = 1'b1;
            end else if (scan_state == qat_pkg::MODE_PESC) begin
               r.out_byte = ch;
               r.store = 1'b1;
               scan_state = qat_pkg::MODE_PLAIN;
            end else if (ch == qat_pkg::CH_BSLASH) begin
               scan_state = qat_pkg::MODE_PESC;
            end else if (is_separator(ch)) begin
               r.store = 1'b1;
               r.arg_end = 1'b1;
               scan_state = qat_pkg::MODE_SEEK;
            end else begin
               r.out_byte = ch;
               r.store = 1'b1;
            end
         end
         default: begin
            if (ch == qat_pkg::CH_NUL) begin
               r.line_end = 1'b1;
            end else if (!is_separator(ch)) begin
               // Any other byte opens an argument; past the limit it is not counted.
               r.new_arg = 1'b1;
               r.arg_index = arg_total[3:0];
               if (arg_total < MAX_ARGS - 1) begin
                  arg_is_recorded = 1'b1;
                  arg_total++;
               end else begin
                  arg_is_recorded = 1'b0;
               end
               r.recorded = arg_is_recorded;
               if (ch == qat_pkg::CH_QUOTE) begin
                  scan_state = qat_pkg::MODE_QUOTED;
               end else if (ch == qat_pkg::CH_BSLASH) begin
                  scan_state = qat_pkg::MODE_PESC;
               end else begin
                  r.out_byte = ch;
                  r.store = 1'b1;
                  scan_state = qat_pkg::MODE_PLAIN;
               end
            end
         end
      endcase
      if (in_arg) begin
         r.arg_index = arg_is_recorded ? 4'(arg_total - 1) : arg_total[3:0];
         r.recorded = arg_is_recorded;
      end
      if (r.line_end) begin
         r.arg_count = arg_total[3:0];
         scan_state = qat_pkg::MODE_SEEK;
         arg_total = 0;
         arg_is_recorded = 1'b0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers. Every line byte goes through push_byte so that a
   // pending drain request lands on the next byte queued.
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] ch);
      line_byte_type b;
      b.ch = ch;
      b.drain = drain_next;
      drain_next = 1'b0;
      line_bytes_q.push_back(b);
   endtask

   function automatic logic [7:0] random_blank();
      return ($urandom_range(0, 2) == 0) ? qat_pkg::CH_SPACE
                                         : 8'($urandom_range(qat_pkg::CH_TAB, qat_pkg::CH_CR));
   endfunction

   // A byte with no special meaning anywhere in the line.
   function automatic logic [7:0] ordinary_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (is_separator(c) || c == qat_pkg::CH_QUOTE || c == qat_pkg::CH_BSLASH);
      return c;
   endfunction

   task automatic push_escape();
      push_byte(qat_pkg::CH_BSLASH);
      push_byte(8'($urandom_range(1, 255)));
   endtask

   // Body of a plain argument: ordinary bytes, escape pairs and bare quotes.
   task automatic push_plain_body(input int len);
      int pick;
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) push_byte(ordinary_char());
         else if (pick < 9) push_escape();
         else push_byte(qat_pkg::CH_QUOTE);
      end
   endtask

   // One line of mostly well-formed arguments; some lines run past the
   // argument limit, some leave a quote open and some end on a backslash.
   task automatic build_random_line();
      int  n_args;
      int  kind;
      int  len;
      bit  quote_open;
      quote_open = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         // Noise: arbitrary bytes, zeros included.
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)));
         push_byte(qat_pkg::CH_NUL);
         return;
      end
      n_args = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
      for (int i = 0; i < n_args; i++) begin
         if (i > 0 || $urandom_range(0, 1)) begin
            len = $urandom_range(1, 2);
            for (int k = 0; k < len; k++) push_byte(random_blank());
         end
         kind = $urandom_range(0, 3);
         len = $urandom_range(0, 4);
         if (kind == 2) begin
            push_byte(qat_pkg::CH_QUOTE);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 5))
                  0: push_byte(random_blank());
                  1: push_escape();
                  default: push_byte(ordinary_char());
               endcase
            end
            if (i == n_args - 1 && $urandom_range(0, 7) == 0) quote_open = 1'b1;
            else push_byte(qat_pkg::CH_QUOTE);
         end else begin
            if (kind == 3) push_escape();
            else push_byte(ordinary_char());
            push_plain_body(len);
            if (i == n_args - 1 && $urandom_range(0, 9) == 0) push_byte(qat_pkg::CH_BSLASH);
         end
      end
      if (!quote_open && $urandom_range(0, 3) == 0) push_byte(random_blank());
      push_byte(qat_pkg::CH_NUL);
   endtask

   function automatic bit may_idle();
      return !(cycle_count >= CALM_FIRST && cycle_count < CALM_LAST);
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: at each rising edge it records a taken request beat, predicts
   // its result, and checks any result beat against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      byte_taken = !reset && req_tvalid && req_tready;
      if (byte_taken) begin
         token_results_q.push_back(tokenize_byte(req_tdata));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_results_q.size() == 0) begin
            $error("result beat with no prediction pending: tdata 'h%0h tlast %0b",
                   rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            qat_pkg::rsp_type want;
            want = token_results_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_tdata[qat_pkg::OUT_BYTE_MSB:0]);
            check_field("store", 8'(want.store), 8'(rsp_tdata[qat_pkg::STORE_BIT]));
            check_field("new_arg", 8'(want.new_arg), 8'(rsp_tdata[qat_pkg::NEW_ARG_BIT]));
            check_field("arg_end", 8'(want.arg_end), 8'(rsp_tdata[qat_pkg::ARG_END_BIT]));
            check_field("arg_index", 8'(want.arg_index), 8'(rsp_tdata[14:11]));
            check_field("recorded", 8'(want.recorded), 8'(rsp_tdata[15]));
            check_field("quote_error", 8'(want.quote_error),
                        8'(rsp_tdata[qat_pkg::QUOTE_ERR_BIT]));
            check_field("arg_count", 8'(want.arg_count),
                        8'(rsp_tdata[qat_pkg::ARG_CNT_MSB:qat_pkg::ARG_CNT_LSB]));
            check_field("tdata padding", 8'h00, 8'(rsp_tdata[23:21]));
            check_field("line_end", 8'(want.line_end), 8'(rsp_tlast));
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** quoted_argument_tokenizer_unit: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: all inputs change on the falling edge. A new byte is offered
   // only once the previous beat was taken; a byte marked for draining waits
   // until no prediction is left outstanding.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(may_idle() && $urandom_range(0, 99) < IDLE_PCT);
         if (!req_tvalid || byte_taken) begin
            if (line_bytes_q.size() > 0
                && !(line_bytes_q[0].drain && token_results_q.size() > 0)
                && !(may_idle() && $urandom_range(0, 99) < IDLE_PCT)) begin
               next_byte = line_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_byte.ch;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   initial begin
      // Directed lines, one special case after another.
      // Separators while seeking produce empty beats.
      push_byte(qat_pkg::CH_SPACE);
      push_byte(qat_pkg::CH_TAB);
      push_byte(qat_pkg::CH_CR);
      // A plain argument opened by a high byte, holding a bare quote and an
      // escaped space, closed by a line feed.
      push_byte(8'hFF);
      push_byte(qat_pkg::CH_QUOTE);
      push_byte(qat_pkg::CH_BSLASH);
      push_byte(qat_pkg::CH_SPACE);
      push_byte(8'h0A);
      // A quoted argument with an escaped quote and an inner space.
      push_byte(qat_pkg::CH_QUOTE);
      push_byte(qat_pkg::CH_BSLASH);
      push_byte(qat_pkg::CH_QUOTE);
      push_byte(qat_pkg::CH_SPACE);
      push_byte(qat_pkg::CH_QUOTE);
      // An argument opened by a backslash, with the line ending in its escape.
      push_byte(qat_pkg::CH_BSLASH);
      push_byte(qat_pkg::CH_NUL);
      // An empty line.
      push_byte(qat_pkg::CH_NUL);
      // Line end inside a quoted escape, then inside an open quote.
      push_byte(qat_pkg::CH_QUOTE);
      push_byte(qat_pkg::CH_BSLASH);
      push_byte(qat_pkg::CH_NUL);
      push_byte(qat_pkg::CH_QUOTE);
      push_byte(8'h41);
      push_byte(qat_pkg::CH_NUL);
      // Line end directly after a plain argument.
      push_byte(8'h80);
      push_byte(8'h7F);
      push_byte(qat_pkg::CH_NUL);

      // The random part starts from an empty pipeline, and drains once more
      // about halfway through.
      drain_next = 1'b1;
      while (line_bytes_q.size() < ITEM_TARGET / 2) build_random_line();
      drain_next = 1'b1;
      while (line_bytes_q.size() < ITEM_TARGET) build_random_line();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (line_bytes_q.size() > 0 || req_tvalid) @(posedge clock);
      while (token_results_q.size() > 0) @(posedge clock);
      // Keep watching for stray result beats.
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** quoted_argument_tokenizer_unit: PASSED **");
      end else begin
         $display("** quoted_argument_tokenizer_unit: FAILED **");
      end
      $finish;
   end

endmodule
